/* rtl/core/psrh_pkg.sv */
// ----------------------------------------------------------------------------
// PC sample region histogram package
// Shared types, widths and constants of the region histogram block.
// ----------------------------------------------------------------------------
package psrh_pkg;

	localparam int REGIONS_DEF = 32;
	localparam int IDX_IN_W    = 5;
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = 32;
	localparam int PCT_W       = 7;
	localparam int NUM_W       = 39;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 80;
	localparam int OP_W        = 2;

	localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
	localparam logic [NUM_W-1:0] PCT_SCALE = 39'd100;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} psrh_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_CNT_RD,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} psrh_state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] pct;
	} div_rsp_t;

endpackage

/* rtl/core/psrh_div.sv */
// ----------------------------------------------------------------------------
// PC sample region histogram share divider
// Bit-serial restoring divider that yields a share percentage saturated at 100.
// ----------------------------------------------------------------------------
module psrh_div import psrh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(NUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [PCT_W-1:0]  quo_q;
	logic              ovf_q;

	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W-1:0]  rem_d;
	logic              last;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_d = ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
	assign last  = cnt_q == STEP_W'(NUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_d;
			quo_q <= {quo_q[PCT_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[PCT_W-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.pct  = (ovf_q || (quo_q > PCT_MAX)) ? PCT_MAX : quo_q;

endmodule

/* rtl/core/pc_sample_region_histogram.sv */
// ----------------------------------------------------------------------------
// PC sample region histogram
// Sampling profiler that counts program counter samples per address region.
// ----------------------------------------------------------------------------
// Each input word is one command, selected by s_tuser, and yields exactly one
// output word. A load or clear goes straight to the output. A sample examines
// the regions in index order until the first match or the last region, because
// a single comparator walks the bounds memory one region at a time, with a read
// state and a compare state per region. A read fetches the count and, when the
// total is nonzero, starts the bit-serial divider that forms the percentage one
// quotient bit per cycle; a read of an index beyond the table goes to the output.
// The block takes no new word while a command is in progress; a finished
// output word waits in its own register while the next command is accepted.
module pc_sample_region_histogram import psrh_pkg::*; #(
	parameter int REGIONS = REGIONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// region_index, lower_bound, upper_bound, program_counter, zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic [OP_W-1:0]        s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// hit, hit_region, region_count, running total, percent, no_samples, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

	psrh_state_t state_q, state_d;

	psrh_op_t            op;
	logic [IDX_IN_W-1:0] in_idx;
	logic [ADDR_W-1:0]   in_lo;
	logic [ADDR_W-1:0]   in_hi;
	logic [ADDR_W-1:0]   in_pc;
	logic                in_ok;
	logic [IDX_W-1:0]    in_addr;

	logic accept;
	logic out_free;
	logic ld_we;
	logic clr;
	logic scan_start;
	logic read_start;
	logic hit_we;
	logic scan_next;
	logic mul_en;
	logic pct_ld;
	logic out_ld;
	logic match;
	logic last;

	logic [2*ADDR_W-1:0] bnd_mem [REGIONS];
	logic [REGIONS-1:0]  bnd_vld_q;
	logic [2*ADDR_W-1:0] bnd_rd_q;
	logic                bnd_rv_q;

	logic [CNT_W-1:0]    hits_mem [REGIONS];
	logic [REGIONS-1:0]  hits_vld_q;
	logic [CNT_W-1:0]    hits_rd_q;
	logic                hits_rv_q;
	logic [CNT_W-1:0]    hits_val;

	logic [IDX_W-1:0]    addr_q;
	logic [ADDR_W-1:0]   pc_q;
	logic [CNT_W-1:0]    total_q;

	logic                r_hit_q;
	logic [IDX_IN_W-1:0] r_region_q;
	logic [CNT_W-1:0]    r_count_q;
	logic [PCT_W-1:0]    r_pct_q;
	logic                r_none_q;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign op      = psrh_op_t'(s_tuser);
	assign in_idx  = s_tdata[4:0];
	assign in_lo   = s_tdata[36:5];
	assign in_hi   = s_tdata[68:37];
	assign in_pc   = s_tdata[100:69];
	assign in_ok   = 32'(in_idx) < 32'(REGIONS);
	assign in_addr = IDX_W'(in_idx);

	assign out_free = !m_valid_q || m_tready;
	assign hits_val = hits_rv_q ? hits_rd_q : '0;
	assign match    = bnd_rv_q && (pc_q >= bnd_rd_q[ADDR_W-1:0])
		&& (pc_q < bnd_rd_q[2*ADDR_W-1:ADDR_W]);
	assign last     = addr_q == IDX_W'(REGIONS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (op) inside
						OP_LOAD, OP_CLEAR: state_d = ST_DONE;
						OP_SAMPLE:         state_d = ST_SCAN_RD;
						OP_READ:           state_d = in_ok ? ST_CNT_RD : ST_DONE;
						default:           state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: state_d = (match || last) ? ST_DONE : ST_SCAN_RD;
			ST_CNT_RD:   state_d = ST_MUL;
			ST_MUL:      state_d = (total_q == '0) ? ST_DONE : ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = state_q == ST_IDLE;
		accept     = s_tvalid && (state_q == ST_IDLE);
		ld_we      = accept && (op == OP_LOAD) && in_ok;
		clr        = accept && (op == OP_CLEAR);
		scan_start = accept && (op == OP_SAMPLE);
		read_start = accept && (op == OP_READ) && in_ok;
		hit_we     = (state_q == ST_SCAN_CMP) && match;
		scan_next  = (state_q == ST_SCAN_CMP) && !match && !last;
		mul_en     = state_q == ST_MUL;
		pct_ld     = (state_q == ST_DIV) && div_rsp.done;
		out_ld     = (state_q == ST_DONE) && out_free;
	end

	assign div_req.start = mul_en && (total_q != '0);
	assign div_req.num   = {{(NUM_W-CNT_W){1'b0}}, hits_val} * PCT_SCALE;
	assign div_req.den   = total_q;

	psrh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			total_q    <= '0;
			bnd_vld_q  <= '0;
			bnd_rv_q   <= 1'b0;
			hits_vld_q <= '0;
			hits_rv_q  <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			bnd_rv_q  <= bnd_vld_q[addr_q];
			hits_rv_q <= hits_vld_q[addr_q];
			if (ld_we) begin
				bnd_vld_q[in_addr] <= 1'b1;
			end
			if (clr) begin
				hits_vld_q <= '0;
				total_q    <= '0;
			end else if (hit_we) begin
				hits_vld_q[addr_q] <= 1'b1;
				total_q            <= total_q + 1'b1;
			end
			if (scan_start) begin
				addr_q <= '0;
			end else if (read_start) begin
				addr_q <= in_addr;
			end else if (scan_next) begin
				addr_q <= addr_q + 1'b1;
			end
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			bnd_mem[in_addr] <= {in_hi, in_lo};
		end
		bnd_rd_q <= bnd_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (hit_we) begin
			hits_mem[addr_q] <= hits_val + 1'b1;
		end
		hits_rd_q <= hits_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q       <= in_pc;
			r_hit_q    <= 1'b0;
			r_region_q <= '0;
			r_count_q  <= '0;
			r_pct_q    <= '0;
			r_none_q   <= (op == OP_READ) && (total_q == '0);
		end
		if (hit_we) begin
			r_hit_q    <= 1'b1;
			r_region_q <= IDX_IN_W'(addr_q);
		end
		if (mul_en) begin
			r_count_q <= hits_val;
		end
		if (pct_ld) begin
			r_pct_q <= div_rsp.pct;
		end
		if (out_ld) begin
			m_data_q <= {2'b00, r_none_q, r_pct_q, total_q, r_count_q, r_region_q, r_hit_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
